// ===== rtl/btrt_pkg.sv =====
// btrt_pkg: shared types, constants and helper functions of the byte to radix text core
// microcode word layout, step addresses, register indexes and character tables
// no dependencies
package btrt_pkg;

   localparam int MAX_DIGITS = 8;
   localparam int PC_W       = 4;
   localparam int ND_W       = 4;
   localparam int ADDR_W     = 5;
   localparam int DATA_W     = 32;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   typedef enum logic [2:0] {
      REG_RADIX          = 3'd0,
      REG_DIGIT_ROTATION = 3'd1,
      REG_ZERO_PAD       = 3'd2,
      REG_SPACE_ENABLE   = 3'd3,
      REG_ALIGN_WIDTH    = 3'd4,
      REG_BYTES_PER_LINE = 3'd5
   } reg_index_type;

   typedef enum logic [3:0] {
      OP_WAIT_IN,
      OP_DIV,
      OP_SAVE_ROT,
      OP_SAVE_DIGIT,
      OP_PAD,
      OP_SPACE_SET,
      OP_EMIT_SPACE,
      OP_EMIT_DIGIT,
      OP_EMIT_LINE,
      OP_EMIT_EOS
   } op_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_QUOT_NZ,
      COND_PAD_MORE,
      COND_SPACE_MORE,
      COND_DIGIT_MORE
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [PC_W-1:0]   target;
   } uword_type;

   localparam logic [PC_W-1:0] STEP_WAIT       = 4'd0;
   localparam logic [PC_W-1:0] STEP_ROT_DIV_A  = 4'd1;
   localparam logic [PC_W-1:0] STEP_ROT_DIV_B  = 4'd2;
   localparam logic [PC_W-1:0] STEP_SAVE_ROT   = 4'd3;
   localparam logic [PC_W-1:0] STEP_DIG_DIV_A  = 4'd4;
   localparam logic [PC_W-1:0] STEP_DIG_DIV_B  = 4'd5;
   localparam logic [PC_W-1:0] STEP_SAVE_DIGIT = 4'd6;
   localparam logic [PC_W-1:0] STEP_PAD        = 4'd7;
   localparam logic [PC_W-1:0] STEP_SPACE_SET  = 4'd8;
   localparam logic [PC_W-1:0] STEP_SPACES     = 4'd9;
   localparam logic [PC_W-1:0] STEP_DIGITS     = 4'd10;
   localparam logic [PC_W-1:0] STEP_LINE_NL    = 4'd11;
   localparam logic [PC_W-1:0] STEP_EOS_NL     = 4'd12;

   // control store: falls through to the next step unless the jump condition holds
   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type w;
      begin
         w = '{op: OP_WAIT_IN, cond: COND_NEVER, target: STEP_WAIT};
         case (pc)
            STEP_WAIT:       w = '{op: OP_WAIT_IN,    cond: COND_NEVER,      target: STEP_WAIT};
            STEP_ROT_DIV_A:  w = '{op: OP_DIV,        cond: COND_NEVER,      target: STEP_WAIT};
            STEP_ROT_DIV_B:  w = '{op: OP_DIV,        cond: COND_NEVER,      target: STEP_WAIT};
            STEP_SAVE_ROT:   w = '{op: OP_SAVE_ROT,   cond: COND_NEVER,      target: STEP_WAIT};
            STEP_DIG_DIV_A:  w = '{op: OP_DIV,        cond: COND_NEVER,      target: STEP_WAIT};
            STEP_DIG_DIV_B:  w = '{op: OP_DIV,        cond: COND_NEVER,      target: STEP_WAIT};
            STEP_SAVE_DIGIT: w = '{op: OP_SAVE_DIGIT, cond: COND_QUOT_NZ,    target: STEP_DIG_DIV_A};
            STEP_PAD:        w = '{op: OP_PAD,        cond: COND_PAD_MORE,   target: STEP_PAD};
            STEP_SPACE_SET:  w = '{op: OP_SPACE_SET,  cond: COND_NEVER,      target: STEP_WAIT};
            STEP_SPACES:     w = '{op: OP_EMIT_SPACE, cond: COND_SPACE_MORE, target: STEP_SPACES};
            STEP_DIGITS:     w = '{op: OP_EMIT_DIGIT, cond: COND_DIGIT_MORE, target: STEP_DIGITS};
            STEP_LINE_NL:    w = '{op: OP_EMIT_LINE,  cond: COND_NEVER,      target: STEP_WAIT};
            STEP_EOS_NL:     w = '{op: OP_EMIT_EOS,   cond: COND_ALWAYS,     target: STEP_WAIT};
            default:         w = '{op: OP_WAIT_IN,    cond: COND_NEVER,      target: STEP_WAIT};
         endcase
         return w;
      end
   endfunction

   // radix 0 and 1 act as 2, 63 acts as 62
   function automatic logic [5:0] eff_radix(input logic [5:0] r);
      logic [5:0] b;
      begin
         if (r < 6'd2) b = 6'd2;
         else if (r > 6'd62) b = 6'd62;
         else b = r;
         return b;
      end
   endfunction

   // least k with b**k >= 255, clamped to 2..8
   function automatic logic [ND_W-1:0] pad_width(input logic [5:0] b);
      logic [ND_W-1:0] k;
      begin
         if (b <= 6'd2) k = 4'd8;
         else if (b == 6'd3) k = 4'd6;
         else if (b <= 6'd6) k = 4'd4;
         else if (b <= 6'd15) k = 4'd3;
         else k = 4'd2;
         return k;
      end
   endfunction

   function automatic logic [7:0] symbol_of(input logic [5:0] v);
      logic [7:0] c;
      logic [5:0] lo;
      begin
         lo = v - 6'd36;
         if (v < 6'd10) c = CHAR_ZERO + {2'b00, v};
         else if (v < 6'd36) c = CHAR_UPPER_A + {2'b00, v} - 8'd10;
         else c = CHAR_LOWER_A + {3'b000, lo[4:0]};
         return c;
      end
   endfunction

endpackage

// ===== rtl/btrt_if.sv =====
// btrt_if: valid/ready channel interfaces of the byte to radix text core
// request carries one byte, response carries one character
// no dependencies
interface btrt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_stream;

   modport source(output valid, output byte_value, output end_of_stream, input ready);
   modport sink(input valid, input byte_value, input end_of_stream, output ready);
endinterface

interface btrt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_of_run;

   modport source(output valid, output char_code, output last_of_run, input ready);
   modport sink(input valid, input char_code, input last_of_run, output ready);
endinterface

// ===== rtl/byte_to_radix_text_core.sv =====
// byte_to_radix_text_core: writes each byte as ASCII digits in radix 2..62
// microcoded sequencer over a shared division step, digit buffer and output register
// depends on btrt_pkg, btrt_if, btrt_div_step
// per byte: rotation division, digit divisions, padding, spaces, digits, line break,
// and end-of-stream newline; no new byte is taken until all of these are done
// the division step, run once for the rotation and once per digit, sets the pace
// reset is synchronous, active high; control and config registers reset, line count to 0
module byte_to_radix_text_core (
   input  logic                          clock,
   input  logic                          reset,
   btrt_req_if.sink                      req_ch,
   btrt_rsp_if.source                    rsp_ch,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [btrt_pkg::ADDR_W-1:0]   paddr,
   input  logic [btrt_pkg::DATA_W-1:0]   pwdata,
   output logic [btrt_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);
   import btrt_pkg::*;

   // configuration registers
   logic [5:0]  radix_ff;
   logic [7:0]  rotation_ff;
   logic        pad_en_ff;
   logic        space_en_ff;
   logic [3:0]  align_ff;
   logic [15:0] bpl_ff;

   // sequencer and datapath
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [15:0]     line_cnt_ff, line_cnt_in;
   logic            line_nl_ff, line_nl_in;
   logic            eos_ff, eos_in;
   logic [7:0]      byte_ff, byte_in;
   logic [7:0]      dvd_ff, dvd_in;
   logic [5:0]      rem_ff, rem_in;
   logic [5:0]      rot_ff, rot_in;
   logic [ND_W-1:0] nd_ff, nd_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic [5:0]      dig_buf_ff [MAX_DIGITS];
   logic            buf_we;
   logic [5:0]      buf_wdata;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_char_ff, rsp_char_in;
   logic            rsp_last_ff, rsp_last_in;

   uword_type   uw;
   logic [5:0]  b_eff;
   logic [ND_W-1:0] pad_w;
   logic [7:0]  div_dvd;
   logic [5:0]  div_rem;
   logic [6:0]  dig_sum;
   logic [5:0]  dig_val;
   logic [3:0]  sp_cnt;
   logic        in_fire, out_free, emit_req, emit_fire, stall, jump;
   logic [7:0]  emit_char;
   logic        emit_last;
   logic        cfg_wr;

   assign uw     = ucode_rom(pc_ff);
   assign b_eff  = eff_radix(radix_ff);
   assign pad_w  = pad_width(b_eff);
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   btrt_div_step u_div (
      .dvd     (dvd_ff),
      .rem     (rem_ff),
      .divisor (b_eff),
      .dvd_out (div_dvd),
      .rem_out (div_rem)
   );

   // digit plus rotation, both below the radix
   assign dig_sum = {1'b0, rem_ff} + {1'b0, rot_ff};
   assign dig_val = (dig_sum >= {1'b0, b_eff}) ? 6'(dig_sum - {1'b0, b_eff}) : dig_sum[5:0];
   assign sp_cnt  = (align_ff > nd_ff) ? (align_ff - nd_ff) : 4'd0;

   assign req_ch.ready = (uw.op == OP_WAIT_IN);
   assign in_fire      = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      emit_req  = 1'b0;
      emit_char = CHAR_SPACE;
      emit_last = 1'b0;
      case (uw.op)
         OP_EMIT_SPACE: begin
            emit_req = (cnt_ff != 5'd0);
         end
         OP_EMIT_DIGIT: begin
            emit_req  = 1'b1;
            emit_char = symbol_of(dig_buf_ff[3'(nd_ff - 4'd1)]);
            emit_last = (nd_ff == 4'd1) && !line_nl_ff && !eos_ff;
         end
         OP_EMIT_LINE: begin
            emit_req  = line_nl_ff;
            emit_char = CHAR_NEWLINE;
            emit_last = !eos_ff;
         end
         OP_EMIT_EOS: begin
            emit_req  = eos_ff;
            emit_char = CHAR_NEWLINE;
            emit_last = 1'b1;
         end
         default: begin
            emit_req = 1'b0;
         end
      endcase
   end

   assign emit_fire = emit_req && out_free;
   assign stall     = ((uw.op == OP_WAIT_IN) && !req_ch.valid) || (emit_req && !out_free);

   always_comb begin
      case (uw.cond)
         COND_NEVER:      jump = 1'b0;
         COND_ALWAYS:     jump = 1'b1;
         COND_QUOT_NZ:    jump = (dvd_ff != 8'd0);
         COND_PAD_MORE:   jump = pad_en_ff && (nd_ff < pad_w);
         COND_SPACE_MORE: jump = (cnt_ff != 5'd0);
         COND_DIGIT_MORE: jump = (nd_ff != 4'd1);
         default:         jump = 1'b0;
      endcase
   end

   always_comb begin
      pc_in        = stall ? pc_ff : (jump ? uw.target : pc_ff + 4'd1);
      line_cnt_in  = line_cnt_ff;
      line_nl_in   = line_nl_ff;
      eos_in       = eos_ff;
      byte_in      = byte_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      rot_in       = rot_ff;
      nd_in        = nd_ff;
      cnt_in       = cnt_ff;
      buf_we       = 1'b0;
      buf_wdata    = dig_val;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (uw.op)
         OP_WAIT_IN: begin
            if (in_fire) begin
               byte_in = req_ch.byte_value;
               eos_in  = req_ch.end_of_stream;
               dvd_in  = rotation_ff;
               rem_in  = 6'd0;
               line_nl_in = 1'b0;
               if (bpl_ff != 16'd0) begin
                  if (line_cnt_ff >= bpl_ff - 16'd1) begin
                     line_nl_in  = 1'b1;
                     line_cnt_in = 16'd0;
                  end else begin
                     line_cnt_in = line_cnt_ff + 16'd1;
                  end
               end
            end
         end
         OP_DIV: begin
            dvd_in = div_dvd;
            rem_in = div_rem;
         end
         OP_SAVE_ROT: begin
            rot_in = rem_ff;
            dvd_in = byte_ff;
            rem_in = 6'd0;
            nd_in  = 4'd0;
         end
         OP_SAVE_DIGIT: begin
            buf_we = 1'b1;
            nd_in  = nd_ff + 4'd1;
            rem_in = 6'd0;
         end
         OP_PAD: begin
            if (jump) begin
               buf_we    = 1'b1;
               buf_wdata = rot_ff;
               nd_in     = nd_ff + 4'd1;
            end
         end
         OP_SPACE_SET: begin
            cnt_in = space_en_ff ? (5'(sp_cnt) + 5'd1) : 5'd0;
         end
         OP_EMIT_SPACE: begin
            if (emit_fire) cnt_in = cnt_ff - 5'd1;
         end
         OP_EMIT_DIGIT: begin
            if (emit_fire) nd_in = nd_ff - 4'd1;
         end
         default: begin
            nd_in = nd_ff;
         end
      endcase
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= STEP_WAIT;
         rsp_valid_ff <= 1'b0;
         line_cnt_ff  <= 16'd0;
         nd_ff        <= '0;
         radix_ff     <= 6'd10;
         rotation_ff  <= 8'd0;
         pad_en_ff    <= 1'b0;
         space_en_ff  <= 1'b0;
         align_ff     <= 4'd0;
         bpl_ff       <= 16'd0;
      end else begin
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         line_cnt_ff  <= line_cnt_in;
         nd_ff        <= nd_in;
         if (cfg_wr) begin
            case (reg_index_type'(paddr[4:2]))
               REG_RADIX:          radix_ff    <= pwdata[5:0];
               REG_DIGIT_ROTATION: rotation_ff <= pwdata[7:0];
               REG_ZERO_PAD:       pad_en_ff   <= pwdata[0];
               REG_SPACE_ENABLE:   space_en_ff <= pwdata[0];
               REG_ALIGN_WIDTH:    align_ff    <= pwdata[3:0];
               REG_BYTES_PER_LINE: bpl_ff      <= pwdata[15:0];
               default:            bpl_ff      <= bpl_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      line_nl_ff  <= line_nl_in;
      eos_ff      <= eos_in;
      byte_ff     <= byte_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      rot_ff      <= rot_in;
      cnt_ff      <= cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (buf_we) dig_buf_ff[nd_ff[2:0]] <= buf_wdata;
   end

   always_comb begin
      case (reg_index_type'(paddr[4:2]))
         REG_RADIX:          prdata = {26'd0, radix_ff};
         REG_DIGIT_ROTATION: prdata = {24'd0, rotation_ff};
         REG_ZERO_PAD:       prdata = {31'd0, pad_en_ff};
         REG_SPACE_ENABLE:   prdata = {31'd0, space_en_ff};
         REG_ALIGN_WIDTH:    prdata = {28'd0, align_ff};
         REG_BYTES_PER_LINE: prdata = {16'd0, bpl_ff};
         default:            prdata = '0;
      endcase
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.char_code   = rsp_char_ff;
   assign rsp_ch.last_of_run = rsp_last_ff;

   // digit count never runs past the buffer
   a_nd_bound: assert property (@(posedge clock) disable iff (reset)
      nd_ff <= 4'(MAX_DIGITS))
      else $error("digit count past buffer depth");

   // remainder and rotation stay below the radix when a digit is stored
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (uw.op == OP_SAVE_DIGIT) |-> (rem_ff < b_eff) && (rot_ff < b_eff))
      else $error("digit or rotation not reduced modulo radix");

   // digit emission always has a stored digit to show
   a_emit_digit: assert property (@(posedge clock) disable iff (reset)
      (uw.op == OP_EMIT_DIGIT) |-> (nd_ff != 4'd0))
      else $error("digit emission with empty buffer");

   // a new byte is only taken once the last character has been loaded
   a_last_before_next: assert property (@(posedge clock) disable iff (reset)
      (uw.op == OP_EMIT_EOS) && !stall |=> rsp_last_ff)
      else $error("run ended without a last character");

endmodule

// ===== rtl/btrt_div_step.sv =====
// btrt_div_step: four restoring division steps of an 8-bit dividend by a 6-bit divisor
// quotient bits shift in at the bottom as dividend bits leave the top
// depends on btrt_pkg
module btrt_div_step (
   input  logic [7:0] dvd,
   input  logic [5:0] rem,
   input  logic [5:0] divisor,
   output logic [7:0] dvd_out,
   output logic [5:0] rem_out
);
   import btrt_pkg::*;

   always_comb begin
      logic [7:0] d;
      logic [5:0] r;
      logic [6:0] t;
      logic       q;
      d = dvd;
      r = rem;
      for (int i = 0; i < 4; i++) begin
         t = {r, d[7]};
         q = (t >= {1'b0, divisor});
         d = {d[6:0], q};
         r = q ? 6'(t - {1'b0, divisor}) : t[5:0];
      end
      dvd_out = d;
      rem_out = r;
   end

endmodule
